>>> sv/ppli_pkg.sv
// ----------------------------------------------------------------------------
// ppli_pkg
// Shared types and constants for the pressure PID unit with a leaky
// integrator: datapath widths, fixed-point constants, register map and
// sequencer states.
// ----------------------------------------------------------------------------
package ppli_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int TARGET_W = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int DRIVE_W  = 16;
    localparam int ERR_W    = 26;
    localparam int DIFF_W   = 27;
    localparam int INTEG_W  = 40;

    // Shift-add datapath: accumulator holds the full sum of the three products
    localparam int ACC_W    = 58;
    localparam int CNT_W    = 4;
    localparam int FRAC_W   = 16;

    // APB side
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Fixed-point constants
    localparam logic [GAIN_W-1:0]        DECAY_Q16    = 16'd65143;
    localparam logic signed [ERR_W-1:0]  DEAD_BAND_Q8 = 26'sd256;
    localparam logic [INTEG_W-1:0]       INTEG_MAX    = 40'h7F_FFFF_FFFF;
    localparam logic [INTEG_W-1:0]       INTEG_MIN    = 40'h80_0000_0000;
    localparam logic [DRIVE_W-1:0]       DRIVE_MAX    = 16'h7FFF;
    localparam logic [DRIVE_W-1:0]       DRIVE_MIN    = 16'h8000;
    localparam logic [ACC_W-1:0]         ROUND_NEG    = 58'h000_0000_0000_FFFF;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_GAIN_P  = 3'd0,
        REG_GAIN_I  = 3'd1,
        REG_GAIN_D  = 3'd2,
        REG_LIMIT   = 3'd3,
        REG_SCALE   = 3'd4
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ERROR,
        ST_DECAY,
        ST_INTEG,
        ST_PTERM,
        ST_ITERM,
        ST_DTERM,
        ST_DRIVE,
        ST_CLAMP
    } state_t;

endpackage

>>> sv/pressure_pid_leaky_integral_unit.sv
// ----------------------------------------------------------------------------
// pressure_pid_leaky_integral_unit
// Pressure-loop PID controller with leaky integral and clamped drive output,
// built around one bit-serial shift-add multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_t*: one transaction per control tick carries the raw ADC
//   sample and the target pressure. Output stream m_t*: one transaction per
//   input carries the clamped drive increment (m_tdata) and the limited flag
//   (m_tuser). Gains, limit and ADC scale are written over the APB port,
//   by the user only while the block is idle; the block does not enforce
//   this. prdata returns the register selected by paddr. Every product is
//   formed one multiplier bit per cycle in a single shift-add accumulator:
//   scale, optional integral decay, then the P, I and D terms back to back.
//   Inside the dead band the integral decay and update are skipped. s_tready
//   returns in the same cycle that the result appears in the output
//   register. Only one item is in flight at a time.
//   The output register decouples the sides: a new item is accepted while a
//   result still waits; if the receiver stalls, the next result holds in the
//   final step until the output register is free.
//   Reset clears the configuration registers, integral, previous error and the
//   output valid flag, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module pressure_pid_leaky_integral_unit
    import ppli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [11:0] pressure_sample, [27:12] target_pressure
    // Output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [15:0] drive_increment
    output logic              m_tuser,   // [0] limited
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Configuration registers
    logic [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg, scale_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Sequencer and datapath registers
    state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    mcand_reg, mcand_next;
    logic [GAIN_W-1:0]   mult_reg, mult_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic [ERR_W-1:0]    err_reg, err_next;
    logic [ERR_W-1:0]    prev_reg, prev_next;
    logic [INTEG_W-1:0]  integ_reg, integ_next;
    logic [DRIVE_W-1:0]  drv_reg, drv_next;
    logic                sat_reg, sat_next;
    logic                out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]  out_drive_reg, out_drive_next;
    logic                out_lim_reg, out_lim_next;

    // Shared combinational terms
    logic               mul_last;
    logic               out_free;
    logic [ERR_W-1:0]   err_calc;
    logic               outside_band;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   acc_step;
    logic [ACC_W-1:0]   acc_rnd;
    logic [INTEG_W:0]   integ_sum;
    logic [ACC_W-FRAC_W-1:0] drive_q;
    logic [DIFF_W-1:0]  diff;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign mul_last = (cnt_reg == {CNT_W{1'b1}});
    assign out_free = !out_valid_reg || m_tready;

    // Error: target in Q8 minus the scaled sample (product bits 27:8)
    assign err_calc = {2'b00, target_reg, 8'h00} - {6'b0, acc_reg[27:8]};
    assign outside_band = ($signed(err_calc) > DEAD_BAND_Q8)
                       || ($signed(err_calc) < -DEAD_BAND_Q8);

    // One shift-add step: add the multiplicand when the multiplier bit is set
    assign addend   = mult_reg[0] ? mcand_reg : '0;
    assign acc_step = acc_reg + addend;

    // Truncate toward zero on the divide by 65536
    assign acc_rnd  = acc_reg + (acc_reg[ACC_W-1] ? ROUND_NEG : '0);
    assign drive_q  = acc_rnd[ACC_W-1:FRAC_W];
    assign integ_sum = {acc_rnd[FRAC_W+INTEG_W-1], acc_rnd[FRAC_W+INTEG_W-1:FRAC_W]}
                     + {{(INTEG_W+1-ERR_W){err_reg[ERR_W-1]}}, err_reg};

    assign diff = {err_reg[ERR_W-1], err_reg} - {prev_reg[ERR_W-1], prev_reg};

    // Configuration access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_GAIN_P: prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_p_reg};
            REG_GAIN_I: prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_i_reg};
            REG_GAIN_D: prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_d_reg};
            REG_LIMIT:  prdata = {{(DATA_W-LIMIT_W){1'b0}}, limit_reg};
            REG_SCALE:  prdata = {{(DATA_W-GAIN_W){1'b0}}, scale_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= '0;
            scale_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_GAIN_P: gain_p_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_I: gain_i_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_D: gain_d_reg <= pwdata[GAIN_W-1:0];
                REG_LIMIT:  limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_SCALE:  scale_reg  <= pwdata[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SCALE;
            ST_SCALE: if (mul_last) state_next = ST_ERROR;
            ST_ERROR: state_next = outside_band ? ST_DECAY : ST_PTERM;
            ST_DECAY: if (mul_last) state_next = ST_INTEG;
            ST_INTEG: state_next = ST_PTERM;
            ST_PTERM: if (mul_last) state_next = ST_ITERM;
            ST_ITERM: if (mul_last) state_next = ST_DTERM;
            ST_DTERM: if (mul_last) state_next = ST_DRIVE;
            ST_DRIVE: state_next = ST_CLAMP;
            ST_CLAMP: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mult_next      = mult_reg;
        target_next    = target_reg;
        err_next       = err_reg;
        prev_next      = prev_reg;
        integ_next     = integ_reg;
        drv_next       = drv_reg;
        sat_next       = sat_reg;
        out_drive_next = out_drive_reg;
        out_lim_next   = out_lim_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;

        unique case (state_reg)
            // Take the item, start the scale product
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    target_next = s_tdata[SAMPLE_W+TARGET_W-1:SAMPLE_W];
                    mcand_next  = {{(ACC_W-SAMPLE_W){1'b0}}, s_tdata[SAMPLE_W-1:0]};
                    mult_next   = scale_reg;
                    acc_next    = '0;
                    cnt_next    = '0;
                end
            end
            // Advance one multiplier bit
            ST_SCALE, ST_DECAY, ST_DTERM:
            begin
                acc_next   = acc_step;
                mcand_next = mcand_reg << 1;
                mult_next  = mult_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
            end
            // Form the error, start the decay or the P term
            ST_ERROR:
            begin
                err_next = err_calc;
                acc_next = '0;
                cnt_next = '0;
                if (outside_band)
                begin
                    mcand_next = {{(ACC_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
                    mult_next  = DECAY_Q16;
                end
                else
                begin
                    mcand_next = {{(ACC_W-ERR_W){err_calc[ERR_W-1]}}, err_calc};
                    mult_next  = gain_p_reg;
                end
            end
            // Add the error to the decayed integral, saturate, start the P term
            ST_INTEG:
            begin
                if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
                    integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
                else
                    integ_next = integ_sum[INTEG_W-1:0];
                mcand_next = {{(ACC_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mult_next  = gain_p_reg;
                acc_next   = '0;
                cnt_next   = '0;
            end
            // P term, then load the integral
            ST_PTERM:
            begin
                acc_next = acc_step;
                cnt_next = cnt_reg + 1'b1;
                if (mul_last)
                begin
                    mcand_next = {{(ACC_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
                    mult_next  = gain_i_reg;
                end
                else
                begin
                    mcand_next = mcand_reg << 1;
                    mult_next  = mult_reg >> 1;
                end
            end
            // I term, then load the error difference
            ST_ITERM:
            begin
                acc_next = acc_step;
                cnt_next = cnt_reg + 1'b1;
                if (mul_last)
                begin
                    mcand_next = {{(ACC_W-DIFF_W){diff[DIFF_W-1]}}, diff};
                    mult_next  = gain_d_reg;
                end
                else
                begin
                    mcand_next = mcand_reg << 1;
                    mult_next  = mult_reg >> 1;
                end
            end
            // Scale down the sum, saturate to 16 bits and keep the error for the D term
            ST_DRIVE:
            begin
                prev_next = err_reg;
                if (drive_q[ACC_W-FRAC_W-1:DRIVE_W-1]
                    != {(ACC_W-FRAC_W-DRIVE_W+1){drive_q[ACC_W-FRAC_W-1]}})
                begin
                    drv_next = drive_q[ACC_W-FRAC_W-1] ? DRIVE_MIN : DRIVE_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    drv_next = drive_q[DRIVE_W-1:0];
                    sat_next = 1'b0;
                end
            end
            // Clamp to the increment limit and hand over to the output register
            ST_CLAMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if ($signed(drv_reg) > $signed({1'b0, limit_reg}))
                    begin
                        out_drive_next = {1'b0, limit_reg};
                        out_lim_next   = 1'b1;
                    end
                    else if ($signed({drv_reg[DRIVE_W-1], drv_reg})
                             < -$signed({2'b00, limit_reg}))
                    begin
                        out_drive_next = -{1'b0, limit_reg};
                        out_lim_next   = 1'b1;
                    end
                    else
                    begin
                        out_drive_next = drv_reg;
                        out_lim_next   = sat_reg;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        mcand_reg     <= mcand_next;
        mult_reg      <= mult_next;
        target_reg    <= target_next;
        err_reg       <= err_next;
        drv_reg       <= drv_next;
        sat_reg       <= sat_next;
        out_drive_reg <= out_drive_next;
        out_lim_reg   <= out_lim_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_drive_reg;
    assign m_tuser  = out_lim_reg;

endmodule
